// ===== sv/gtcd_pkg.sv =====
// Shared types, constants and tables for the GPS time to calendar date converter.
// Used by the controller, the datapath, the top level and the port checker.
package gtcd_pkg;

  localparam int WEEK_W     = 12;
  localparam int SOW_W      = 20;
  localparam int OFF_W      = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam int DOY_W  = 9;
  localparam int YEAR_W = 8;
  localparam int MON_W  = 4;
  localparam int MDAY_W = 5;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;

  // Divider sizing: dividend up to 20 bits, remainder below the largest
  // divisor (86400, 17 bits), quotient below 128. The quotient comes from a
  // 16 by 16 reciprocal product, the remainder from one multiply-subtract.
  localparam int DVD_W  = 20;
  localparam int PART_W = 17;
  localparam int CNT_W  = 2;
  localparam int QUO_W  = 7;
  localparam int DAYS_W = 15;
  localparam int JD_W   = 11;
  localparam int MUL_W  = 16;
  localparam int PROD_W = 32;

  localparam logic [PART_W-1:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [PART_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [PART_W-1:0] SEC_PER_MIN  = 17'd60;
  localparam logic [PART_W-1:0] DAYS_COMMON  = 17'd365;
  localparam logic [JD_W-1:0]   JD_COMMON    = 11'd365;
  localparam logic [JD_W-1:0]   JD_LEAP      = 11'd366;
  localparam logic [DAYS_W-1:0] WEEK_DAYS    = 15'd7;
  localparam logic [DAYS_W-1:0] EPOCH_SHIFT  = 15'd5;
  localparam logic [YEAR_W-1:0] BASE_YEAR    = 8'd80;
  localparam logic [MON_W-1:0]  LAST_MONTH   = 4'd12;

  // Rounded-up reciprocals of the odd part of each divisor:
  // 2^23/675, 2^21/225, 2^14/15, 2^24/365
  localparam logic [MUL_W-1:0]  RECIP_DAY    = 16'd12428;
  localparam logic [MUL_W-1:0]  RECIP_HOUR   = 16'd9321;
  localparam logic [MUL_W-1:0]  RECIP_MIN    = 16'd1093;
  localparam logic [MUL_W-1:0]  RECIP_YEAR   = 16'd45965;

  // quotient step, then remainder step
  localparam logic [CNT_W-1:0]  DIV_STEPS    = 2'd2;

  typedef enum logic [1:0] {
    OP_DAY  = 2'd0,
    OP_HOUR = 2'd1,
    OP_MIN  = 2'd2,
    OP_YEAR = 2'd3
  } div_op_t;

  typedef struct packed {
    logic    load;
    logic    sub;
    logic    div_start;
    div_op_t div_op;
    logic    div_step;
    logic    adjust;
    logic    mon_step;
    logic    out_write;
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic div_last;
    logic mon_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [PART_W-1:0] div_divisor(input div_op_t op);
    logic [PART_W-1:0] d;
    unique case (op)
      OP_DAY:  d = SEC_PER_DAY;
      OP_HOUR: d = SEC_PER_HOUR;
      OP_MIN:  d = SEC_PER_MIN;
      OP_YEAR: d = DAYS_COMMON;
      default: d = SEC_PER_DAY;
    endcase
    return d;
  endfunction

  function automatic logic [MUL_W-1:0] div_recip(input div_op_t op);
    logic [MUL_W-1:0] m;
    unique case (op)
      OP_DAY:  m = RECIP_DAY;
      OP_HOUR: m = RECIP_HOUR;
      OP_MIN:  m = RECIP_MIN;
      OP_YEAR: m = RECIP_YEAR;
      default: m = RECIP_DAY;
    endcase
    return m;
  endfunction

  // Days before the start of a month; index 0..12
  function automatic logic [DOY_W-1:0] cum_days(input logic leap, input logic [MON_W-1:0] idx);
    logic [DOY_W-1:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = leap ? 9'd60  : 9'd59;
      4'd3:    d = leap ? 9'd91  : 9'd90;
      4'd4:    d = leap ? 9'd121 : 9'd120;
      4'd5:    d = leap ? 9'd152 : 9'd151;
      4'd6:    d = leap ? 9'd182 : 9'd181;
      4'd7:    d = leap ? 9'd213 : 9'd212;
      4'd8:    d = leap ? 9'd244 : 9'd243;
      4'd9:    d = leap ? 9'd274 : 9'd273;
      4'd10:   d = leap ? 9'd305 : 9'd304;
      4'd11:   d = leap ? 9'd335 : 9'd334;
      4'd12:   d = leap ? 9'd366 : 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/gtcd_ctrl.sv =====
// Sequencing state machine of the GPS time to calendar date converter.
// Depends on gtcd_pkg for the command and status structs.
module gtcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gtcd_pkg::dp_stat_t stat,
  output gtcd_pkg::dp_cmd_t  cmd
);
  import gtcd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SUB   = 7'b0000010,
    S_START = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_ADJ   = 7'b0010000,
    S_MON   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t  state_r, state_nxt;
  div_op_t op_r, op_nxt;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cmd        = '0;
    cmd.div_op = op_r;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        op_nxt    = OP_DAY;
        state_nxt = S_START;
      end
      S_START: begin
        // negative corrected time skips straight to the result
        if (op_r == OP_DAY && stat.neg) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          if (op_r == OP_YEAR) begin
            state_nxt = S_ADJ;
          end else begin
            op_nxt    = div_op_t'(op_r + 2'd1);
            state_nxt = S_START;
          end
        end
      end
      S_ADJ: begin
        cmd.adjust = 1'b1;
        state_nxt  = S_MON;
      end
      S_MON: begin
        if (stat.mon_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.mon_step = 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register can take the item
        if (stat.out_free) begin
          cmd.out_write = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_DAY;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

// ===== sv/gtcd_datapath.sv =====
// Datapath of the GPS time to calendar date converter: input capture, shared
// reciprocal divider, leap-year adjust, month scan and output register. Uses gtcd_pkg.
module gtcd_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [gtcd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  gtcd_pkg::dp_cmd_t                  cmd,
  output gtcd_pkg::dp_stat_t                 stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gtcd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser
);
  import gtcd_pkg::*;

  logic [WEEK_W-1:0] week_r;
  logic [SOW_W-1:0]  sow_r;
  logic [OFF_W-1:0]  off_r;
  logic [SOW_W-1:0]  secs_r;
  logic              neg_r;

  div_op_t           op_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [PART_W-1:0] part_r;
  logic [QUO_W-1:0]  q_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [3:0]        wday_r;
  logic [HOUR_W-1:0] hour_r;
  logic [MIN_W-1:0]  min_r;
  logic [SEC_W-1:0]  sec_r;
  logic [QUO_W-1:0]  yr_r;
  logic [DOY_W-1:0]  jd_r;
  logic [MON_W-1:0]  mon_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  // divider
  logic [MUL_W-1:0]        mul_a;
  logic [PROD_W-1:0]       prod;
  logic [QUO_W-1:0]        quo_nxt;
  logic [QUO_W+PART_W-1:0] qd;
  logic [DVD_W-1:0]        rem_full;
  logic [PART_W-1:0]       part_nxt;
  logic [DAYS_W-1:0]       total_days;
  logic [DVD_W-1:0]        dvd_load;

  // Drop the divisor's power-of-two factor, multiply by the reciprocal of
  // the odd rest and keep the top bits; the remainder is then formed from the registered quotient.
  always_comb begin
    unique case (op_r)
      OP_DAY:  mul_a = MUL_W'(dvd_r[19:7]);
      OP_HOUR: mul_a = MUL_W'(dvd_r[16:4]);
      OP_MIN:  mul_a = MUL_W'(dvd_r[11:2]);
      OP_YEAR: mul_a = MUL_W'(dvd_r[14:0]);
      default: mul_a = MUL_W'(dvd_r[19:7]);
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(div_recip(op_r));
    unique case (op_r)
      OP_DAY:  quo_nxt = prod[29:23];
      OP_HOUR: quo_nxt = prod[27:21];
      OP_MIN:  quo_nxt = prod[20:14];
      OP_YEAR: quo_nxt = prod[30:24];
      default: quo_nxt = prod[29:23];
    endcase
    qd       = (QUO_W+PART_W)'(q_r) * (QUO_W+PART_W)'(div_divisor(op_r));
    rem_full = dvd_r - qd[DVD_W-1:0];
    part_nxt = rem_full[PART_W-1:0];
  end

  assign total_days = DAYS_W'(week_r) * WEEK_DAYS + DAYS_W'(wday_r) + EPOCH_SHIFT;

  // hour and minute divide the previous remainder; day divides secs_r, year the day count
  always_comb begin
    unique case (cmd.div_op)
      OP_DAY:  dvd_load = secs_r;
      OP_HOUR: dvd_load = DVD_W'(part_r);
      OP_MIN:  dvd_load = DVD_W'(part_r);
      OP_YEAR: dvd_load = DVD_W'(total_days);
      default: dvd_load = secs_r;
    endcase
  end

  // leap-day correction of the day within the year
  logic [4:0]        prior;
  logic [JD_W-1:0]   jd_a;
  logic [QUO_W-1:0]  yr_a;
  logic              jd_low;

  always_comb begin
    prior = 5'(({1'b0, q_r} + 8'd3) >> 2);
    jd_a  = JD_W'(part_r[DOY_W-1:0]) + JD_W'(1) - JD_W'(prior);
    yr_a  = q_r;
    jd_low = jd_a[JD_W-1] || (jd_a == '0);
    if (jd_low && (q_r != '0)) begin
      yr_a = q_r - QUO_W'(1);
      jd_a = jd_a + ((yr_a[1:0] != 2'b00) ? JD_COMMON : JD_LEAP);
    end
    if (jd_a[JD_W-1] || (jd_a == '0)) begin
      jd_a = JD_W'(1);
    end
  end

  logic             leap;
  logic [DOY_W-1:0] cum_cur;
  logic [DOY_W-1:0] cum_prev;
  logic [DOY_W-1:0] mday;
  logic [YEAR_W-1:0] year_out;

  assign leap     = (yr_r[1:0] == 2'b00);
  assign cum_cur  = cum_days(leap, mon_r);
  assign cum_prev = cum_days(leap, mon_r - MON_W'(1));
  assign mday     = jd_r - cum_prev;
  assign year_out = YEAR_W'(yr_r) + BASE_YEAR;

  always_comb begin
    stat          = '0;
    stat.neg      = neg_r;
    stat.div_last = (cnt_r == CNT_W'(1));
    stat.mon_done = (mon_r == LAST_MONTH) || (jd_r <= cum_cur);
    stat.out_free = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      week_r <= in_tdata[11:0];
      sow_r  <= in_tdata[31:12];
      off_r  <= in_tdata[39:32];
    end
    if (cmd.sub) begin
      secs_r <= sow_r - SOW_W'(off_r);
      neg_r  <= (sow_r < SOW_W'(off_r));
    end
    if (cmd.div_start) begin
      op_r   <= cmd.div_op;
      dvd_r  <= dvd_load;
      part_r <= '0;
      q_r    <= '0;
      cnt_r  <= DIV_STEPS;
      // take the result of the division just finished
      unique case (cmd.div_op)
        OP_DAY:  ;
        OP_HOUR: wday_r <= q_r[3:0];
        OP_MIN:  hour_r <= q_r[HOUR_W-1:0];
        OP_YEAR: begin
          min_r <= q_r[MIN_W-1:0];
          sec_r <= part_r[SEC_W-1:0];
        end
        default: ;
      endcase
    end else if (cmd.div_step) begin
      if (cnt_r == DIV_STEPS) begin
        q_r <= quo_nxt;
      end else begin
        part_r <= part_nxt;
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.adjust) begin
      yr_r  <= yr_a;
      jd_r  <= jd_a[DOY_W-1:0];
      mon_r <= MON_W'(1);
    end else if (cmd.mon_step) begin
      mon_r <= mon_r + MON_W'(1);
    end
    if (cmd.out_write) begin
      if (neg_r) begin
        out_data_r <= '0;
        out_user_r <= 1'b0;
      end else begin
        out_data_r <= {5'b00000, sec_r, min_r, hour_r, mday[MDAY_W-1:0], mon_r,
                       year_out, jd_r};
        out_user_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sv/gps_time_to_calendar_date.sv =====
// GPS week and seconds of week to UTC calendar date converter, top level.
// Joins gtcd_ctrl and gtcd_datapath; uses gtcd_pkg for widths and structs.
//
// Input channel in_*: one item carries gps_week, seconds_of_week and the
// GPS-minus-UTC offset. Result channel out_*: one item per input with the
// day of year, year since 1900, month, day of month, hour, minute, second;
// out_tuser is the time valid flag. A negative corrected time gives
// out_tuser low and all data zero.
// One item is in work at a time. A shared divider multiplies by a fixed
// reciprocal; each of the four divisions (86400, 3600, 60, 365) takes a load
// step, a quotient step and a remainder step, then a leap correction step
// and a month scan from January up to the month of the day. in_tready is
// high only while the block waits for an item.
// The result sits in an output register; the next item is accepted while
// it waits, and the finished next result holds until the register frees.
// Reset (rst_n low, synchronous) returns to waiting and clears out_tvalid.
module gps_time_to_calendar_date (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // gps_week[11:0], seconds_of_week[31:12], utc_offset[39:32]
  input  logic [gtcd_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // day_of_year[8:0], year_since_1900[16:9], month_number[20:17],
  // day_of_month[25:21], hour_of_day[30:26], minute_of_hour[36:31],
  // second_of_minute[42:37], zero[47:43]
  output logic [gtcd_pkg::OUT_DATA_W-1:0] out_tdata,
  // time_valid[0]
  output logic                            out_tuser
);
  import gtcd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gtcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gtcd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/gtcd_checker.sv =====
// Port-level checks for the GPS time to calendar date converter, bound to
// the top level. Uses gtcd_pkg for the channel widths.
module gtcd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gtcd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import gtcd_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second item taken while one is in work");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid time carries nonzero fields");

  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[20:17] != 4'd0 && out_tdata[20:17] <= 4'd12 &&
      out_tdata[25:21] != 5'd0 && out_tdata[30:26] < 5'd24 &&
      out_tdata[36:31] < 6'd60 && out_tdata[42:37] < 6'd60)
    else $error("calendar field out of range");

endmodule

bind gps_time_to_calendar_date gtcd_checker u_gtcd_checker (.*);

// ===== tb/tb_gps_time_to_calendar_date.sv =====
// Self-checking testbench for gps_time_to_calendar_date: directed calendar corners and
// random GPS times, checked against a date predictor. Depends on gtcd_pkg and the RTL.
module tb_gps_time_to_calendar_date;
  timeunit 1ns;
  timeprecision 1ps;
  import gtcd_pkg::*;

  localparam int unsigned SECS_IN_DAY  = 86400;
  localparam int unsigned SECS_IN_HOUR = 3600;
  localparam int unsigned SECS_IN_MIN  = 60;
  localparam int unsigned DAYS_IN_WEEK = 7;
  localparam int unsigned EPOCH_DAY    = 5;      // week 0 starts on 6 January 1980
  localparam int unsigned YEAR_DAYS    = 365;
  localparam int unsigned LEAP_DAYS    = 366;
  localparam int unsigned YEAR_BIAS    = 80;     // 1980 counted from 1900
  localparam int unsigned LAST_DAY     = 28671;  // a day in week 4095, the last week number
  localparam int          RANDOM_ITEMS = 1100;

  // Input item, packed so that a cast gives the in_tdata layout
  typedef struct packed {
    logic [gtcd_pkg::OFF_W-1:0]  off;
    logic [gtcd_pkg::SOW_W-1:0]  sow;
    logic [gtcd_pkg::WEEK_W-1:0] week;
  } gps_item_t;

  // Result item, packed in the out_tdata layout
  typedef struct packed {
    logic [4:0]                  pad;
    logic [gtcd_pkg::SEC_W-1:0]  sec_of_min;
    logic [gtcd_pkg::MIN_W-1:0]  min_of_hour;
    logic [gtcd_pkg::HOUR_W-1:0] hour_of_day;
    logic [gtcd_pkg::MDAY_W-1:0] mday;
    logic [gtcd_pkg::MON_W-1:0]  month;
    logic [gtcd_pkg::YEAR_W-1:0] year;
    logic [gtcd_pkg::DOY_W-1:0]  doy;
  } cal_date_t;

  typedef struct packed {
    logic      valid;
    cal_date_t date;
  } date_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [gtcd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [gtcd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  int unsigned common_month_start [13] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

  date_result_t pending_dates [$];
  int error_count = 0;
  int items_sent = 0;
  int valid_seen = 0;
  int negative_seen = 0;
  int year_lo = 255;
  int year_hi = 0;
  int burst_left = 0;
  int rx_cycle = 0;
  int rx_hold = 0;

  gps_time_to_calendar_date u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned month_start(input bit leap, input int unsigned idx);
    return common_month_start[idx] + ((leap && idx >= 2) ? 1 : 0);
  endfunction

  function automatic date_result_t predict_date(input gps_item_t it);
    date_result_t r;
    int unsigned  secs, wday, days, yr, rem, leaps, mon;
    int           jd;
    r = '0;
    if (it.sow < it.off) return r;
    secs  = 32'(it.sow) - 32'(it.off);
    wday  = secs / SECS_IN_DAY;
    days  = 32'(it.week) * DAYS_IN_WEEK + wday + EPOCH_DAY;
    yr    = days / YEAR_DAYS;
    rem   = days - yr * YEAR_DAYS;
    leaps = (yr + 3) / 4;
    jd    = int'(rem) + 1 - int'(leaps);
    // fall back into the previous year when the leap days eat the remainder
    if (jd <= 0 && yr > 0) begin
      yr--;
      jd += (yr % 4 != 0) ? YEAR_DAYS : LEAP_DAYS;
    end
    if (jd < 1) jd = 1;
    mon = 1;
    while (mon < 13 && jd > int'(month_start(yr % 4 == 0, mon))) mon++;
    if (mon > 12) mon = 12;
    r.valid            = 1'b1;
    r.date.doy         = DOY_W'(jd);
    r.date.year        = YEAR_W'(yr + YEAR_BIAS);
    r.date.month       = MON_W'(mon);
    r.date.mday        = MDAY_W'(jd - int'(month_start(yr % 4 == 0, mon - 1)));
    r.date.hour_of_day = HOUR_W'((secs % SECS_IN_DAY) / SECS_IN_HOUR);
    r.date.min_of_hour = MIN_W'((secs % SECS_IN_HOUR) / SECS_IN_MIN);
    r.date.sec_of_min  = SEC_W'(secs % SECS_IN_MIN);
    return r;
  endfunction

  function automatic gps_item_t make_item(input int unsigned week, input int unsigned sow,
                                          input int unsigned off);
    gps_item_t it;
    it.week = WEEK_W'(week);
    it.sow  = SOW_W'(sow);
    it.off  = OFF_W'(off);
    return it;
  endfunction

  // Item landing on a given day count since 1 January 1980 after the offset
  function automatic gps_item_t day_item(input int unsigned day_count, input int unsigned sod,
                                         input int unsigned off);
    int unsigned d;
    d = day_count - EPOCH_DAY;
    return make_item(d / DAYS_IN_WEEK, (d % DAYS_IN_WEEK) * SECS_IN_DAY + sod + off, off);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Sender: bursts of random length with random gaps; hold valid across a burst
  task automatic send_item(input gps_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_dates.push_back(predict_date(it));
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver: cycle through always ready, coin flips, long stalls and a fixed pattern
  always @(negedge clk) begin : drive_ready
    int mode;
    rx_cycle++;
    mode = (rx_cycle / 2500) % 4;
    case (mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: begin
        if (rx_hold > 0) begin
          rx_hold--;
        end else if (out_tready) begin
          out_tready <= 1'b0;
          rx_hold = $urandom_range(10, 200);
        end else begin
          out_tready <= 1'b1;
          rx_hold = $urandom_range(0, 3);
        end
      end
      default: out_tready <= ((rx_cycle % 7) < 3);
    endcase
  end

  always @(posedge clk) begin : check_results
    date_result_t want;
    cal_date_t    got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tuser=%0b tdata=%h",
                 $time, out_tuser, out_tdata);
        error_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("time_valid", want.valid, out_tuser);
        check_field("day_of_year", want.date.doy, got.doy);
        check_field("year_since_1900", want.date.year, got.year);
        check_field("month_number", want.date.month, got.month);
        check_field("day_of_month", want.date.mday, got.mday);
        check_field("hour_of_day", want.date.hour_of_day, got.hour_of_day);
        check_field("minute_of_hour", want.date.min_of_hour, got.min_of_hour);
        check_field("second_of_minute", want.date.sec_of_min, got.sec_of_min);
        check_field("tdata padding", want.date.pad, got.pad);
        if (want.valid) begin
          valid_seen++;
          if (want.date.year < year_lo) year_lo = want.date.year;
          if (want.date.year > year_hi) year_hi = want.date.year;
        end else begin
          negative_seen++;
        end
      end
    end
  end

  // Field extremes, the negative-time boundary and alternating bit patterns
  task automatic test_corner_inputs();
    send_item(make_item(0, 0, 0));
    send_item(make_item(0, 0, 255));
    send_item(make_item(0, 254, 255));
    send_item(make_item(0, 255, 255));
    send_item(make_item(4095, 1048575, 0));
    send_item(make_item(4095, 1048575, 255));
    send_item(make_item(2047, 604799, 18));
    send_item(make_item(1, 604799, 0));
    send_item(make_item(12'hAAA, 20'hAAAAA, 8'hAA));
    send_item(make_item(12'h555, 20'h55555, 8'h55));
  endtask

  // Year ends, leap days, month turns and the last second of a day
  task automatic test_calendar_edges();
    send_item(day_item(58, 0, 0));            // 28 Feb 1980
    send_item(day_item(59, 43200, 17));       // 29 Feb 1980
    send_item(day_item(365, 86399, 0));       // 31 Dec 1980, last second
    send_item(day_item(366, 0, 1));           // 1 Jan 1981
    send_item(day_item(1460, 86399, 255));    // 31 Dec 1983
    send_item(day_item(1461, 0, 0));          // 1 Jan 1984
    send_item(day_item(1520, 3661, 5));       // 29 Feb 1984
    send_item(day_item(1521, 0, 0));          // 1 Mar 1984
    send_item(day_item(1826, 86399, 18));     // 31 Dec 1984, day 366
    send_item(day_item(1827, 0, 18));         // 1 Jan 1985
    send_item(day_item(27818, 45296, 37));    // 29 Feb 2056
    send_item(day_item(LAST_DAY, 86399, 0));
  endtask

  task automatic test_random_stream(input int count);
    gps_item_t   it;
    int unsigned kind, yr, mon, bound_day;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // corrected time below zero
        it.off  = OFF_W'($urandom_range(1, 255));
        it.sow  = SOW_W'($urandom_range(0, it.off - 1));
        it.week = WEEK_W'($urandom);
      end else if (kind < 30) begin
        // within a day of a month or year boundary
        yr  = $urandom_range(1, 77);
        mon = $urandom_range(0, 12);
        bound_day = yr * YEAR_DAYS + (yr + 3) / 4 + month_start(yr % 4 == 0, mon)
                    + $urandom_range(0, 2) - 1;
        it = day_item(bound_day, $urandom_range(0, SECS_IN_DAY - 1), $urandom_range(0, 255));
      end else if (kind < 40) begin
        // seconds past the end of the week
        it = make_item($urandom, $urandom_range(604800, 1048575), $urandom_range(0, 255));
      end else begin
        it = make_item($urandom, $urandom_range(0, 604799),
                       ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 20));
      end
      send_item(it);
    end
  endtask

  initial begin
    int drain;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_corner_inputs();
    test_calendar_edges();
    test_random_stream(RANDOM_ITEMS);
    in_tvalid <= 1'b0;
    drain = 0;
    while (pending_dates.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    if (pending_dates.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0 left, actual %0d", $time,
               pending_dates.size(), pending_dates.size());
      error_count++;
    end
    $display("Sent %0d items: %0d valid times over years %0d to %0d, %0d negative times.",
             items_sent, valid_seen, year_lo + 1900, year_hi + 1900, negative_seen);
    $display("Mismatches and missing or extra results: %0d", error_count);
    if (error_count == 0) begin
      $display("PASS gps_time_to_calendar_date");
    end else begin
      $display("FAIL gps_time_to_calendar_date");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL gps_time_to_calendar_date");
    $finish;
  end

endmodule
